@@ src/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg
// shared types and constants of the frame stability detector
// ----------------------------------------------------------------------------
package fsd_pkg;

    // frame memory depth, one byte per pixel position
    localparam int MAX_PIXELS = 65536;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 24;
    localparam int CNT_W  = 17;
    localparam int THR_W  = 16;
    localparam int RUN_W  = 8;
    localparam int BUD_W  = 12;
    localparam int STAT_W = 2;

    localparam int POS_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = $clog2(MAX_PIXELS);

    // width that holds both sides of the mean test
    localparam int LHS_W  = SUM_W + 8;
    localparam int RHS_W  = THR_W + POS_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W + 1 : RHS_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQ_RUN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd512;
    localparam logic [RUN_W-1:0] REQ_RUN_RESET   = 8'd2;
    localparam logic [BUD_W-1:0] BUDGET_RESET    = 12'd30;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_SETTLING = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_STABLE   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_WEAK     = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } pix_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              compared;
        logic [SUM_W-1:0]  diff_total;
        logic [CNT_W-1:0]  frame_pixels;
    } res_item_t;

endpackage

@@ src/frame_stability_detector_top.sv @@
// ----------------------------------------------------------------------------
// frame_stability_detector_top
// frame difference detector that reports when a picture has settled
// ----------------------------------------------------------------------------
// usage
//   pixel channel (pix_valid / pix_stall / pix_item): one gray pixel per item
//   in raster order, frame_end set on the last pixel of a frame
//   result channel (res_valid / res_stall / res_item): one item per frame,
//   issued for the pixel that carries frame_end
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
//   threshold_q8, required_run and frame_budget; always ready; the user must
//   write them only while the block is idle; the block does not enforce it
// timing
//   one pixel per cycle while pix_stall is low, set by the read-first
//   frame memory port; a result is registered from stage 1 at frame_end
// reset
//   asynchronous, active low; counters, session state and valids clear,
//   registers take their defaults; frame memory content is not cleared, its
//   output is only compared at positions written by the previous frame
// back-pressure
//   pixels keep flowing while a result waits; a frame_end item that finds
//   the result register full and stalled holds the pipe and raises pix_stall
// ----------------------------------------------------------------------------
module frame_stability_detector_top (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  fsd_pkg::pix_item_t                pix_item,

    output logic                              res_valid,
    input  logic                              res_stall,
    output fsd_pkg::res_item_t                res_item,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [fsd_pkg::THR_W-1:0] threshold_reg;
    logic [fsd_pkg::RUN_W-1:0] req_run_reg;
    logic [fsd_pkg::BUD_W-1:0] budget_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= fsd_pkg::THRESHOLD_RESET;
            req_run_reg   <= fsd_pkg::REQ_RUN_RESET;
            budget_reg    <= fsd_pkg::BUDGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fsd_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[fsd_pkg::THR_W-1:0];
                fsd_pkg::REG_REQ_RUN:   req_run_reg   <= cfg_data[fsd_pkg::RUN_W-1:0];
                fsd_pkg::REG_BUDGET:    budget_reg    <= cfg_data[fsd_pkg::BUD_W-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and stage control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_last_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_fire;
    logic pix_accept;

    // result slot is free when empty or being taken this cycle
    assign out_free   = !out_valid_reg || !res_stall;
    // only a frame end needs the result slot
    assign s1_fire    = s1_valid_reg && (!s1_last_reg || out_free);
    assign pix_stall  = s1_valid_reg && !s1_fire;
    assign pix_accept = pix_valid && !pix_stall;

    // ------------------------------------------------------------------
    // stage 0: pixel position and frame memory
    // ------------------------------------------------------------------
    logic [fsd_pkg::POS_W-1:0]  pos_reg;
    logic [fsd_pkg::POS_W-1:0]  pos_next;
    logic                       pos_in_range;
    logic [fsd_pkg::PIX_W-1:0]  frame_mem [fsd_pkg::MAX_PIXELS];
    logic [fsd_pkg::PIX_W-1:0]  old_pix_reg;

    // positions past the memory depth are neither stored nor compared
    assign pos_in_range = pos_reg < fsd_pkg::POS_W'(fsd_pkg::MAX_PIXELS);

    always_comb
    begin
        pos_next = pos_reg;
        if (pix_accept)
        begin
            if (pix_item.frame_end)
                pos_next = '0;
            else if (pos_in_range)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // read-first port: the previous frame's pixel comes out as the new one
    // goes in at the same position
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            old_pix_reg <= frame_mem[pos_reg[fsd_pkg::ADDR_W-1:0]];
            if (pos_in_range)
                frame_mem[pos_reg[fsd_pkg::ADDR_W-1:0]] <= pix_item.pixel;
        end
    end

    // stage 1 input register
    logic [fsd_pkg::PIX_W-1:0] s1_pixel_reg;
    logic [fsd_pkg::POS_W-1:0] s1_pos_reg;
    logic                      s1_in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg    <= pix_item.pixel;
            s1_pos_reg      <= pos_reg;
            s1_in_range_reg <= pos_in_range;
            s1_last_reg     <= pix_item.frame_end;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: accumulate, and at frame end decide the outcome
    // ------------------------------------------------------------------
    logic                       prev_valid_reg;
    logic [fsd_pkg::POS_W-1:0]  prev_count_reg;
    logic [fsd_pkg::SUM_W-1:0]  sum_reg;
    logic [fsd_pkg::RUN_W-1:0]  quiet_run_reg;
    logic [fsd_pkg::BUD_W-1:0]  frames_seen_reg;

    logic                       prev_valid_next;
    logic [fsd_pkg::POS_W-1:0]  prev_count_next;
    logic [fsd_pkg::SUM_W-1:0]  sum_next;
    logic [fsd_pkg::RUN_W-1:0]  quiet_run_next;
    logic [fsd_pkg::BUD_W-1:0]  frames_seen_next;

    logic                       cmp_pixel;
    logic [fsd_pkg::PIX_W-1:0]  abs_diff;
    logic [fsd_pkg::SUM_W:0]    sum_wide;
    logic [fsd_pkg::SUM_W-1:0]  sum_cur;
    logic [fsd_pkg::POS_W-1:0]  frame_count;
    logic                       compared;
    logic [fsd_pkg::CMP_W-1:0]  lhs;
    logic [fsd_pkg::CMP_W-1:0]  rhs;
    logic                       quiet;
    logic [fsd_pkg::RUN_W-1:0]  run_after;
    logic [fsd_pkg::BUD_W-1:0]  seen_after;
    logic [fsd_pkg::STAT_W-1:0] status;

    assign cmp_pixel = s1_in_range_reg && prev_valid_reg && (s1_pos_reg < prev_count_reg);
    assign abs_diff  = (s1_pixel_reg > old_pix_reg) ? (s1_pixel_reg - old_pix_reg)
                                                    : (old_pix_reg - s1_pixel_reg);
    assign sum_wide  = {1'b0, sum_reg} + {{(fsd_pkg::SUM_W + 1 - fsd_pkg::PIX_W){1'b0}}, abs_diff};

    always_comb
    begin
        // running sum saturates at full scale
        if (!cmp_pixel)
            sum_cur = sum_reg;
        else if (sum_wide[fsd_pkg::SUM_W])
            sum_cur = '1;
        else
            sum_cur = sum_wide[fsd_pkg::SUM_W-1:0];

        frame_count = s1_in_range_reg ? (s1_pos_reg + 1'b1) : s1_pos_reg;
        compared    = prev_valid_reg && (prev_count_reg == frame_count);

        // mean below threshold without division: sum*256 < thr*count
        lhs   = fsd_pkg::CMP_W'({sum_cur, 8'h00});
        rhs   = fsd_pkg::CMP_W'(threshold_reg) * fsd_pkg::CMP_W'(frame_count);
        quiet = compared && (lhs < rhs);

        if (!compared)
            run_after = quiet_run_reg;
        else if (!quiet)
            run_after = '0;
        else if (quiet_run_reg != '1)
            run_after = quiet_run_reg + 1'b1;
        else
            run_after = quiet_run_reg;

        seen_after = (frames_seen_reg != '1) ? frames_seen_reg + 1'b1 : frames_seen_reg;

        // stable wins over an exhausted budget
        if (quiet && (run_after >= req_run_reg))
            status = fsd_pkg::STATUS_STABLE;
        else if (seen_after >= budget_reg)
            status = fsd_pkg::STATUS_WEAK;
        else
            status = fsd_pkg::STATUS_SETTLING;

        prev_valid_next  = prev_valid_reg;
        prev_count_next  = prev_count_reg;
        sum_next         = sum_reg;
        quiet_run_next   = quiet_run_reg;
        frames_seen_next = frames_seen_reg;

        if (s1_fire)
        begin
            if (!s1_last_reg)
                sum_next = sum_cur;
            else
            begin
                sum_next = '0;
                if (status != fsd_pkg::STATUS_SETTLING)
                begin
                    // session restart
                    quiet_run_next   = '0;
                    frames_seen_next = '0;
                    prev_valid_next  = 1'b0;
                    prev_count_next  = '0;
                end
                else
                begin
                    quiet_run_next   = run_after;
                    frames_seen_next = seen_after;
                    prev_valid_next  = 1'b1;
                    prev_count_next  = frame_count;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg  <= 1'b0;
            prev_count_reg  <= '0;
            sum_reg         <= '0;
            quiet_run_reg   <= '0;
            frames_seen_reg <= '0;
        end
        else
        begin
            prev_valid_reg  <= prev_valid_next;
            prev_count_reg  <= prev_count_next;
            sum_reg         <= sum_next;
            quiet_run_reg   <= quiet_run_next;
            frames_seen_reg <= frames_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    fsd_pkg::res_item_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (!res_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_reg.status       <= status;
            out_reg.compared     <= compared;
            out_reg.diff_total   <= compared ? sum_cur : '0;
            out_reg.frame_pixels <= fsd_pkg::CNT_W'(frame_count);
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_uncompared_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.compared |-> res_item.diff_total == '0)
        else $error("uncompared frame reports a nonzero difference");

    a_session_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg && (status != fsd_pkg::STATUS_SETTLING)
        |=> !prev_valid_reg && (frames_seen_reg == '0) && (quiet_run_reg == '0))
        else $error("outcome did not restart the session");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= fsd_pkg::POS_W'(fsd_pkg::MAX_PIXELS))
        else $error("pixel position beyond frame memory depth");

    a_sum_idle_at_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> sum_reg == '0)
        else $error("running sum not cleared at frame end");

endmodule
